/* hw/rtl/heartbeat_watchdog_table_defines.svh */
// ----------------------------------------------------------------------------
// heartbeat watchdog table: assertion macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_WATCHDOG_TABLE_DEFINES_SVH
`define HEARTBEAT_WATCHDOG_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HBWD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HBWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hbwd_pkg.sv */
// ----------------------------------------------------------------------------
// hbwd_pkg
// shared types, codes and constants of the heartbeat watchdog table
// ----------------------------------------------------------------------------
package hbwd_pkg;

  localparam int unsigned DEVICE_COUNT_DEF = 16;
  localparam int unsigned TYPE_SLOTS_DEF   = 4;
  localparam int unsigned TIME_BITS_DEF    = 32;

  localparam int unsigned DEV_FIELD_W = 4;
  localparam int unsigned TYPE_W      = 16;
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned AGE_W       = 32;
  localparam int unsigned HEALTH_W    = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [CFG_DATA_W-1:0] WARN_RST  = 32'd1000;
  localparam logic [CFG_DATA_W-1:0] FAULT_RST = 32'd3000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_WARN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd6;

  typedef enum logic [1:0] {
    MODE_CONNECT,
    MODE_FRAME,
    MODE_SWEEP,
    MODE_QUERY
  } mode_e;

  typedef enum logic [HEALTH_W-1:0] {
    H_INACTIVE,
    H_WAITING,
    H_HEALTHY,
    H_WARNING,
    H_FAULT
  } health_e;

  typedef enum logic {
    KIND_EVENT,
    KIND_REPLY
  } kind_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] warn;
    logic [CFG_DATA_W-1:0] fault;
  } thr_t;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic             ge_fault;
    logic             ge_warn;
  } age_res_t;

  typedef struct packed {
    logic                   kind;
    logic [DEV_FIELD_W-1:0] dev;
    logic [HEALTH_W-1:0]    health;
    logic [AGE_W-1:0]       age;
  } result_t;

endpackage

/* hw/rtl/hbwd_cfg.sv */
// ----------------------------------------------------------------------------
// hbwd_cfg
// threshold and telemetry type registers, with the type slot matcher
// ----------------------------------------------------------------------------
module hbwd_cfg #(
  parameter int unsigned TYPE_SLOTS = hbwd_pkg::TYPE_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hbwd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hbwd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [hbwd_pkg::TYPE_W-1:0]      type_i,
  output hbwd_pkg::thr_t                   thr_o,
  output logic                             match_o
);
  import hbwd_pkg::*;

  logic [CFG_DATA_W-1:0] warn_q;
  logic [CFG_DATA_W-1:0] fault_q;
  logic [TYPE_SLOTS-1:0] enable_q;
  logic [TYPE_W-1:0]     slot_q [TYPE_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q   <= WARN_RST;
      fault_q  <= FAULT_RST;
      enable_q <= '0;
      for (int i = 0; i < TYPE_SLOTS; i++) begin
        slot_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WARN) begin
        warn_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_FAULT) begin
        fault_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_ENABLE) begin
        enable_q <= cfg_data_i[TYPE_SLOTS-1:0];
      end
      for (int i = 0; i < TYPE_SLOTS; i++) begin
        if (cfg_idx_i == CFG_SLOT0 + CFG_IDX_W'(i)) begin
          slot_q[i] <= cfg_data_i[TYPE_W-1:0];
        end
      end
    end
  end

  always_comb begin
    match_o = 1'b0;
    for (int i = 0; i < TYPE_SLOTS; i++) begin
      match_o = match_o | (enable_q[i] && (slot_q[i] == type_i));
    end
  end

  assign thr_o.warn  = warn_q;
  assign thr_o.fault = fault_q;

endmodule

/* hw/rtl/hbwd_table.sv */
// ----------------------------------------------------------------------------
// hbwd_table
// per-device entry memory with one write and one registered read port
// ----------------------------------------------------------------------------
module hbwd_table #(
  parameter int unsigned DEVICE_COUNT = hbwd_pkg::DEVICE_COUNT_DEF,
  parameter int unsigned TIME_BITS    = hbwd_pkg::TIME_BITS_DEF,
  parameter int unsigned DEV_W        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [DEV_W-1:0]               rd_addr_i,
  output logic                           rd_conn_o,
  output logic [hbwd_pkg::HEALTH_W-1:0]  rd_health_o,
  output logic [TIME_BITS-1:0]           rd_time_o,
  input  logic                           we_i,
  input  logic [DEV_W-1:0]               wr_addr_i,
  input  logic                           wr_conn_i,
  input  logic [hbwd_pkg::HEALTH_W-1:0]  wr_health_i,
  input  logic [TIME_BITS-1:0]           wr_time_i
);
  import hbwd_pkg::*;

  localparam int unsigned EntryW = 1 + HEALTH_W + TIME_BITS;

  logic [EntryW-1:0]       mem_q [DEVICE_COUNT];
  logic [EntryW-1:0]       rd_data_q;
  logic [DEVICE_COUNT-1:0] valid_q;
  logic                    rd_valid_q;
  logic                    rd_in_range;

  assign rd_in_range = (32'(rd_addr_i) < DEVICE_COUNT);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= {wr_conn_i, wr_health_i, wr_time_i};
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // an entry never written reads as disconnected, inactive, time zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= rd_in_range ? valid_q[rd_addr_i] : 1'b0;
    end
  end

  assign rd_conn_o   = rd_valid_q & rd_data_q[EntryW-1];
  assign rd_health_o = rd_valid_q ? rd_data_q[EntryW-2 -: HEALTH_W] : '0;
  assign rd_time_o   = rd_valid_q ? rd_data_q[TIME_BITS-1:0] : '0;

endmodule

/* hw/rtl/hbwd_age_unit.sv */
// ----------------------------------------------------------------------------
// hbwd_age_unit
// shared age subtractor with saturation and threshold compares
// ----------------------------------------------------------------------------
module hbwd_age_unit #(
  parameter int unsigned TIME_BITS = hbwd_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [TIME_BITS-1:0] then_i,
  input  hbwd_pkg::thr_t       thr_i,
  output hbwd_pkg::age_res_t   res_o
);
  import hbwd_pkg::*;

  localparam int unsigned CmpW = (TIME_BITS > AGE_W) ? TIME_BITS : AGE_W;

  logic [TIME_BITS-1:0] diff;
  logic [CmpW-1:0]      diff_ext;

  // time running backwards clamps to zero
  assign diff     = (now_i >= then_i) ? (now_i - then_i) : '0;
  assign diff_ext = CmpW'(diff);

  assign res_o.age      = (diff_ext > CmpW'({AGE_W{1'b1}})) ? '1 : AGE_W'(diff_ext);
  assign res_o.ge_fault = (diff_ext >= CmpW'(thr_i.fault));
  assign res_o.ge_warn  = (diff_ext >= CmpW'(thr_i.warn));

endmodule

/* hw/rtl/heartbeat_watchdog_table.sv */
// ----------------------------------------------------------------------------
// heartbeat_watchdog_table
// per-device heartbeat watchdog with connect, frame, sweep and query commands
// ----------------------------------------------------------------------------
//   Commands enter on s_axis (tuser = mode), results leave on m_axis
//   (tuser = kind, tlast = final result of a command). Thresholds and type
//   slots are set through the cfg write port; the user must write them only
//   while no command is in flight, which the block does not enforce. Connect,
//   frame and query commands have an accept cycle, which launches the table
//   read, and an evaluate step with the shared age unit; any result is on
//   m_axis in the cycle after that step completes. A sweep reads one entry
//   per cycle through the single table read port while the receiver does not
//   stall it, and a final step releases the held result; each change is held
//   back one entry so that the final one carries tlast. s_axis_tready_o is
//   high only while the sequencer is idle. Reset marks every table entry
//   unwritten, so all devices read as disconnected and inactive at time
//   zero; no clearing pass is needed. A stalled receiver keeps the result in
//   the output register; a command may still be accepted, and its evaluate
//   step waits until the output register frees up.
// ----------------------------------------------------------------------------
`include "heartbeat_watchdog_table_defines.svh"

module heartbeat_watchdog_table #(
  parameter int unsigned DEVICE_COUNT = hbwd_pkg::DEVICE_COUNT_DEF,
  parameter int unsigned TYPE_SLOTS   = hbwd_pkg::TYPE_SLOTS_DEF,
  parameter int unsigned TIME_BITS    = hbwd_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // device[3:0], link_up[4], message_type[20:5], now_ms[52:21], zero[55:53]
  input  logic [hbwd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // mode[1:0]
  input  logic [hbwd_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // device_out[3:0], health[6:4], age_ms[38:7], zero[39]
  output logic [hbwd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // kind[0]
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_we_i,
  input  logic [hbwd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hbwd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import hbwd_pkg::*;

  localparam int unsigned DevW = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam logic [DevW-1:0] LastDev = DevW'(DEVICE_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_FLUSH
  } state_e;

  state_e                 state_q;
  mode_e                  mode_q;
  logic [DEV_FIELD_W-1:0] dev_q;
  logic                   link_q;
  logic                   match_q;
  logic                   dvalid_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [DevW-1:0]        idx_q;
  logic                   out_valid_q;
  logic                   out_last_q;
  result_t                out_q;
  logic                   pend_valid_q;
  result_t                pend_q;

  // input unpacking
  mode_e                  in_mode;
  logic [DEV_FIELD_W-1:0] in_dev;
  logic                   in_link;
  logic [TYPE_W-1:0]      in_type;
  logic [NOW_W-1:0]       in_now;
  logic                   in_accept;

  thr_t     thr;
  logic     type_match;
  age_res_t age_res;

  logic                 rd_conn;
  logic [HEALTH_W-1:0]  rd_health;
  logic [TIME_BITS-1:0] rd_time;
  logic [DevW-1:0]      rd_addr;

  logic                 emit;
  logic                 stall;
  logic                 we;
  logic                 tbl_we;
  logic                 wr_conn;
  logic [HEALTH_W-1:0]  wr_health;
  logic [TIME_BITS-1:0] wr_time;
  logic [HEALTH_W-1:0]  sweep_next;
  logic                 out_free;
  logic                 out_load;
  logic                 sweep_busy;
  result_t              res;

  assign in_mode   = mode_e'(s_axis_tuser_i);
  assign in_dev    = s_axis_tdata_i[3:0];
  assign in_link   = s_axis_tdata_i[4];
  assign in_type   = s_axis_tdata_i[20:5];
  assign in_now    = s_axis_tdata_i[52:21];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  hbwd_cfg #(
    .TYPE_SLOTS (TYPE_SLOTS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .type_i     (in_type),
    .thr_o      (thr),
    .match_o    (type_match)
  );

  hbwd_table #(
    .DEVICE_COUNT (DEVICE_COUNT),
    .TIME_BITS    (TIME_BITS),
    .DEV_W        (DevW)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (rd_addr),
    .rd_conn_o   (rd_conn),
    .rd_health_o (rd_health),
    .rd_time_o   (rd_time),
    .we_i        (tbl_we),
    .wr_addr_i   (idx_q),
    .wr_conn_i   (wr_conn),
    .wr_health_i (wr_health),
    .wr_time_i   (wr_time)
  );

  hbwd_age_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_age (
    .now_i  (now_q),
    .then_i (rd_time),
    .thr_i  (thr),
    .res_o  (age_res)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    priority if (age_res.ge_fault) begin
      sweep_next = H_FAULT;
    end else if (age_res.ge_warn) begin
      sweep_next = H_WARNING;
    end else begin
      sweep_next = rd_health;
    end
  end

  // evaluate step for the entry held in the table read register
  always_comb begin
    emit       = 1'b0;
    we         = 1'b0;
    wr_conn    = 1'b1;
    wr_health  = rd_health;
    wr_time    = now_q;
    res.kind   = KIND_EVENT;
    res.dev    = dev_q;
    res.health = rd_health;
    res.age    = '0;
    unique case (mode_q)
      MODE_CONNECT: begin
        wr_conn    = link_q;
        wr_health  = link_q ? H_WAITING : H_INACTIVE;
        we         = dvalid_q;
        emit       = dvalid_q && (rd_health != wr_health);
        res.health = wr_health;
      end
      MODE_FRAME: begin
        wr_health  = H_HEALTHY;
        we         = dvalid_q && rd_conn && match_q;
        emit       = we && (rd_health != H_HEALTHY);
        res.health = H_HEALTHY;
      end
      MODE_SWEEP: begin
        wr_health  = sweep_next;
        wr_time    = rd_time;
        we         = rd_conn && (sweep_next != rd_health);
        emit       = we;
        res.dev    = DEV_FIELD_W'(idx_q);
        res.health = sweep_next;
        res.age    = age_res.age;
      end
      MODE_QUERY: begin
        emit     = 1'b1;
        res.kind = KIND_REPLY;
        if (dvalid_q && rd_conn) begin
          res.health = rd_health;
          res.age    = age_res.age;
        end else begin
          res.health = H_INACTIVE;
        end
      end
      default: ;
    endcase
    // a sweep only needs the output when a held result gets pushed out
    if (mode_q == MODE_SWEEP) begin
      stall = emit && pend_valid_q && !out_free;
    end else begin
      stall = emit && !out_free;
    end
  end

  assign tbl_we = (state_q == S_EVAL) && we && !stall;

  // output register takes a new transaction this cycle
  assign out_load = ((state_q == S_EVAL) && !stall && emit &&
                     ((mode_q != MODE_SWEEP) || pend_valid_q)) ||
                    ((state_q == S_FLUSH) && pend_valid_q && out_free);

  assign sweep_busy = (mode_q == MODE_SWEEP) &&
                      ((state_q == S_EVAL) || (state_q == S_FLUSH));

  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr = (in_mode == MODE_SWEEP) ? '0 : DevW'(in_dev);
    end else if ((state_q == S_EVAL) && (mode_q == MODE_SWEEP) && !stall &&
                 (idx_q != LastDev)) begin
      rd_addr = idx_q + 1'b1;
    end else begin
      rd_addr = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_CONNECT;
      dev_q        <= '0;
      link_q       <= 1'b0;
      match_q      <= 1'b0;
      dvalid_q     <= 1'b0;
      now_q        <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            mode_q   <= in_mode;
            dev_q    <= in_dev;
            link_q   <= in_link;
            match_q  <= type_match;
            dvalid_q <= (32'(in_dev) < DEVICE_COUNT);
            now_q    <= TIME_BITS'(in_now);
            idx_q    <= rd_addr;
            state_q  <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!stall) begin
            if (mode_q == MODE_SWEEP) begin
              // hold the newest change back until we know whether it is the last
              if (emit) begin
                if (pend_valid_q) begin
                  out_q      <= pend_q;
                  out_last_q <= 1'b0;
                end
                pend_q       <= res;
                pend_valid_q <= 1'b1;
              end
              if (idx_q == LastDev) begin
                state_q <= S_FLUSH;
              end else begin
                idx_q <= rd_addr;
              end
            end else begin
              if (emit) begin
                out_q      <= res;
                out_last_q <= 1'b1;
              end
              state_q <= S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_q        <= pend_q;
            out_last_q   <= 1'b1;
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.age, out_q.health, out_q.dev};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_last_q;

  `HBWD_ASSERT_NEXT(a_accept_to_eval, in_accept, state_q == S_EVAL, "accept without evaluate")
  `HBWD_ASSERT_NOW(a_reply_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o, "reply no tlast")
  `HBWD_ASSERT_NOW(a_pend_sweep, pend_valid_q, sweep_busy, "held result outside a sweep")
  `HBWD_ASSERT_NOW(a_health_code, m_axis_tvalid_o, out_q.health <= H_FAULT, "bad health code")

endmodule
